// File: hdl/tep_pkg.sv
`default_nettype none
package tep_pkg;

  localparam int NUM_TYPES   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TYPE_W      = $clog2(NUM_TYPES);
  localparam int CNT_W       = $clog2(NUM_TYPES + 1);
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);
  localparam int CLK_W       = 64;
  localparam int VAL_W       = 31;
  localparam logic [VAL_W-1:0] SAT31 = {VAL_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_ADVANCE    = 3'd0,
    CMD_SKIP       = 3'd1,
    CMD_SCHEDULE   = 3'd2,
    CMD_UNSCHEDULE = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [TYPE_W-1:0] idx;
    logic [CLK_W-1:0]  due;
  } best_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [CLK_W-1:0] due;
    logic [CLK_W-1:0] queued;
  } cell_wr_t;

  function automatic logic [VAL_W-1:0] sat_diff(input logic [CLK_W-1:0] a,
                                               input logic [CLK_W-1:0] b);
    logic [CLK_W-1:0] d;
    d = a - b;
    if (a <= b) return '0;
    if (d > CLK_W'(SAT31)) return SAT31;
    return d[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/timed_event_priority_scheduler.sv
// Schedule and unschedule: the command is registered, then written into its slot cell.
// Query: waits in QUERY while the output register is stalled.
// Advance: min search through the cell chain, one cell per cycle; each fire repeats
// it; output stalls hold fires. Skip first jumps the clock to the earliest due time.
// Results leave through an output register; a run gives at most 16 results.
// Synchronous active-high reset clears the clock, all pending flags and control.
`default_nettype none
module timed_event_priority_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [2:0]  command,
  input  wire logic [3:0]  event_type,
  input  wire logic [30:0] cycles,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             is_fire,
  output logic [3:0]       fired_type,
  output logic [30:0]      lateness,
  output logic             is_scheduled,
  output logic [30:0]      elapsed,
  output logic [30:0]      remaining,
  output logic [30:0]      span,
  output logic             last
);
  import tep_pkg::*;

  state_t state, state_next;
  logic [CLK_W-1:0]  clock_count;
  logic [CNT_W-1:0]  search_cnt;
  logic [FIRE_W-1:0] fire_cnt;
  logic              skip_pend;
  logic              held_valid;
  logic [3:0]        held_type;
  logic [VAL_W-1:0]  held_late;
  logic [2:0]        q_cmd;
  logic [3:0]        q_type;
  logic [VAL_W-1:0]  q_cycles;

  cell_wr_t wr [NUM_TYPES];
  best_t    chain [NUM_TYPES+1];
  logic     pend_v [NUM_TYPES];
  logic [CLK_W-1:0] due_v [NUM_TYPES];
  logic [CLK_W-1:0] que_v [NUM_TYPES];

  best_t best;
  logic  out_free, accept, type_ok, fire_now, do_fire, do_done, do_query;
  logic  q_pend;
  logic [CLK_W-1:0] q_due, q_que;

  assign chain[0] = '0;
  assign best     = chain[NUM_TYPES];
  assign out_free = !res_valid || res_ready;
  assign accept   = cmd_valid && cmd_ready;
  assign type_ok  = 32'(q_type) < NUM_TYPES;
  assign fire_now = best.valid && best.due <= clock_count && fire_cnt < FIRE_W'(MAX_RESULTS);

  for (genvar i = 0; i < NUM_TYPES; i++) begin : g_cell
    always_comb begin
      wr[i].set    = state == ST_IDLE && q_cmd == CMD_SCHEDULE && type_ok &&
                     q_type[TYPE_W-1:0] == TYPE_W'(i) && skip_pend == 1'b0 &&
                     search_cnt == CNT_W'(1);
      wr[i].clr    = (state == ST_IDLE && q_cmd == CMD_UNSCHEDULE && type_ok &&
                      q_type[TYPE_W-1:0] == TYPE_W'(i) && search_cnt == CNT_W'(1)) ||
                     (do_fire && best.idx == TYPE_W'(i));
      wr[i].due    = clock_count + CLK_W'(q_cycles);
      wr[i].queued = clock_count;
    end
    tep_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (TYPE_W'(i)),
      .wr      (wr[i]),
      .best_in (chain[i]),
      .best_out(chain[i+1]),
      .pending (pend_v[i]),
      .due     (due_v[i]),
      .queued  (que_v[i])
    );
  end

  assign q_pend = type_ok && pend_v[q_type[TYPE_W-1:0]];
  assign q_due  = due_v[q_type[TYPE_W-1:0]];
  assign q_que  = que_v[q_type[TYPE_W-1:0]];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_ADVANCE, CMD_SKIP: state_next = ST_SEARCH;
            CMD_QUERY:             state_next = ST_QUERY;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: if (search_cnt == CNT_W'(NUM_TYPES - 1)) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (skip_pend) begin
          if (!best.valid) state_next = ST_IDLE;
        end else if (do_fire) begin
          state_next = ST_SEARCH;
        end else if (do_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_QUERY: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = state == ST_IDLE;
    do_fire   = state == ST_DECIDE && !skip_pend && fire_now &&
                (!held_valid || out_free);
    do_done   = state == ST_DECIDE && !skip_pend && !fire_now &&
                (!held_valid || out_free);
    do_query  = state == ST_QUERY && out_free;
  end

  // search_cnt doubles as a one-shot marker for schedule/unschedule in IDLE
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      clock_count <= '0;
      search_cnt  <= '0;
      fire_cnt    <= '0;
      skip_pend   <= 1'b0;
      held_valid  <= 1'b0;
      res_valid   <= 1'b0;
      q_cmd       <= CMD_QUERY;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      search_cnt <= '0;
      if (accept) begin
        q_cmd      <= command;
        search_cnt <= CNT_W'(1);
        fire_cnt   <= '0;
        skip_pend  <= command == CMD_SKIP;
        if (command == CMD_ADVANCE) clock_count <= clock_count + CLK_W'(cycles);
        if (command == CMD_ADVANCE || command == CMD_SKIP) search_cnt <= '0;
      end
      if (state == ST_SEARCH) search_cnt <= search_cnt + CNT_W'(1);
      if (state == ST_DECIDE && skip_pend) begin
        skip_pend <= 1'b0;
        if (best.valid) clock_count <= best.due;
      end
      if (do_fire || do_done) begin
        if (held_valid) begin
          res_valid <= 1'b1;
          last      <= do_done;
        end
        held_valid <= do_fire;
      end
      if (do_fire) fire_cnt <= fire_cnt + FIRE_W'(1);
      if (do_query) begin
        res_valid <= 1'b1;
        last      <= 1'b1;
      end
    end
    if (accept) begin
      q_type   <= event_type;
      q_cycles <= cycles;
    end
    if (do_fire) begin
      held_type <= 4'(best.idx);
      held_late <= sat_diff(clock_count, best.due);
    end
    if ((do_fire || do_done) && held_valid) begin
      is_fire      <= 1'b1;
      fired_type   <= held_type;
      lateness     <= held_late;
      is_scheduled <= 1'b0;
      elapsed      <= '0;
      remaining    <= '0;
      span         <= '0;
    end
    if (do_query) begin
      is_fire      <= 1'b0;
      fired_type   <= '0;
      lateness     <= '0;
      is_scheduled <= q_pend;
      elapsed      <= q_pend ? sat_diff(clock_count, q_que) : '0;
      remaining    <= q_pend ? sat_diff(q_due, clock_count) : '0;
      span         <= q_pend ? sat_diff(q_due, q_que) : '0;
    end
  end

`ifndef SYNTHESIS
  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FIRE_W'(MAX_RESULTS))
    else $error("fire count over limit");
  a_held_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !held_valid)
    else $error("held result left in idle");
  a_fire_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_fire |-> !is_scheduled && elapsed == '0 && span == '0)
    else $error("fire result carries query fields");
`endif

endmodule
`default_nettype wire

// File: hdl/tep_cell.sv
`default_nettype none
module tep_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tep_pkg::TYPE_W-1:0]    my_idx,
  input  wire tep_pkg::cell_wr_t             wr,
  input  wire tep_pkg::best_t                best_in,
  output tep_pkg::best_t                     best_out,
  output logic                               pending,
  output logic [tep_pkg::CLK_W-1:0]          due,
  output logic [tep_pkg::CLK_W-1:0]          queued
);
  import tep_pkg::*;

  best_t best_next;

  always_comb begin
    best_next = best_in;
    if (pending && (!best_in.valid || due < best_in.due)) begin
      best_next.valid = 1'b1;
      best_next.idx   = my_idx;
      best_next.due   = due;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= 1'b0;
      best_out.valid <= 1'b0;
    end else begin
      best_out.valid <= best_next.valid;
      if (wr.set) begin
        pending <= 1'b1;
      end else if (wr.clr) begin
        pending <= 1'b0;
      end
    end
    best_out.idx <= best_next.idx;
    best_out.due <= best_next.due;
    if (wr.set) begin
      due    <= wr.due;
      queued <= wr.queued;
    end
  end

endmodule
`default_nettype wire

// File: sim/timed_event_priority_scheduler_tb.sv
`timescale 1ns / 1ps
module timed_event_priority_scheduler_tb;
  import tep_pkg::*;

  typedef struct packed {
    logic        is_fire;
    logic [3:0]  fired_type;
    logic [30:0] lateness;
    logic        is_scheduled;
    logic [30:0] elapsed;
    logic [30:0] remaining;
    logic [30:0] span;
    logic        last;
  } event_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic [2:0] command = '0;
  logic [3:0] event_type = '0;
  logic [30:0] cycles = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic is_fire;
  logic [3:0] fired_type;
  logic [30:0] lateness;
  logic is_scheduled;
  logic [30:0] elapsed;
  logic [30:0] remaining;
  logic [30:0] span;
  logic last;

  timed_event_priority_scheduler uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .command(command), .event_type(event_type), .cycles(cycles),
    .res_valid(res_valid), .res_ready(res_ready),
    .is_fire(is_fire), .fired_type(fired_type), .lateness(lateness),
    .is_scheduled(is_scheduled), .elapsed(elapsed), .remaining(remaining),
    .span(span), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [63:0] sched_clock;
  logic        sched_pending [NUM_TYPES];
  logic [63:0] sched_due [NUM_TYPES];
  logic [63:0] sched_queued [NUM_TYPES];
  event_result_t pending_results[$];
  int errors = 0;
  int recv_idle_pct = 34;
  int send_idle_pct = 34;
  int hold_off = 0;

  function automatic logic [30:0] clamp_diff(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a <= b) return '0;
    if (d > 64'h7FFF_FFFF) return 31'h7FFF_FFFF;
    return d[30:0];
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < NUM_TYPES; i++)
      if (sched_pending[i] && (best < 0 || sched_due[i] < sched_due[best])) best = i;
    return best;
  endfunction

  function automatic void fire_due_events();
    int n;
    int t;
    event_result_t r;
    n = 0;
    while (n < MAX_RESULTS) begin
      t = earliest_slot();
      if (t < 0 || sched_due[t] > sched_clock) break;
      sched_pending[t] = 1'b0;
      r = '0;
      r.is_fire = 1'b1;
      r.fired_type = t[3:0];
      r.lateness = clamp_diff(sched_clock, sched_due[t]);
      pending_results.insert(pending_results.size(), r);
      n++;
    end
    if (n > 0) pending_results[$].last = 1'b1;
  endfunction

  function automatic void predict_command(logic [2:0] c, logic [3:0] ty, logic [30:0] cy);
    int e;
    event_result_t r;
    case (c)
      CMD_ADVANCE: begin
        sched_clock = sched_clock + 64'(cy);
        fire_due_events();
      end
      CMD_SKIP: begin
        e = earliest_slot();
        if (e >= 0) begin
          sched_clock = sched_due[e];
          fire_due_events();
        end
      end
      CMD_SCHEDULE: begin
        sched_pending[ty] = 1'b1;
        sched_queued[ty] = sched_clock;
        sched_due[ty] = sched_clock + 64'(cy);
      end
      CMD_UNSCHEDULE: sched_pending[ty] = 1'b0;
      CMD_QUERY: begin
        r = '0;
        r.last = 1'b1;
        if (sched_pending[ty]) begin
          r.is_scheduled = 1'b1;
          r.elapsed = clamp_diff(sched_clock, sched_queued[ty]);
          r.remaining = clamp_diff(sched_due[ty], sched_clock);
          r.span = clamp_diff(sched_due[ty], sched_queued[ty]);
        end
        pending_results.insert(pending_results.size(), r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(logic [2:0] c, logic [3:0] ty, logic [30:0] cy);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    command <= c;
    event_type <= ty;
    cycles <= cy;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predict_command(c, ty, cy);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    event_result_t got;
    event_result_t want;
    if (!rst && res_valid && res_ready) begin
      got = {is_fire, fired_type, lateness, is_scheduled, elapsed, remaining, span, last};
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.is_fire !== want.is_fire) begin
          $error("is_fire exp %0h got %0h", want.is_fire, got.is_fire); errors++;
        end
        if (got.fired_type !== want.fired_type) begin
          $error("fired_type exp %0h got %0h", want.fired_type, got.fired_type); errors++;
        end
        if (got.lateness !== want.lateness) begin
          $error("lateness exp %0h got %0h", want.lateness, got.lateness); errors++;
        end
        if (got.is_scheduled !== want.is_scheduled) begin
          $error("is_scheduled exp %0h got %0h", want.is_scheduled, got.is_scheduled);
          errors++;
        end
        if (got.elapsed !== want.elapsed) begin
          $error("elapsed exp %0h got %0h", want.elapsed, got.elapsed); errors++;
        end
        if (got.remaining !== want.remaining) begin
          $error("remaining exp %0h got %0h", want.remaining, got.remaining); errors++;
        end
        if (got.span !== want.span) begin
          $error("span exp %0h got %0h", want.span, got.span); errors++;
        end
        if (got.last !== want.last) begin
          $error("last exp %0h got %0h", want.last, got.last); errors++;
        end
      end
    end
  end

  function automatic logic [30:0] random_delay();
    case ($urandom_range(9))
      0: return 31'h7FFF_FFFF;
      1: return 31'($urandom);
      2: return '0;
      default: return 31'($urandom_range(60));
    endcase
  endfunction

  task automatic test_directed();
    send_command(CMD_ADVANCE, 4'd0, '0);
    send_command(CMD_SKIP, 4'd0, '0);
    send_command(CMD_QUERY, 4'd15, '0);
    send_command(CMD_SCHEDULE, 4'd15, 31'h7FFF_FFFF);
    send_command(CMD_SCHEDULE, 4'd0, '0);
    send_command(CMD_SCHEDULE, 4'd3, 31'd10);
    send_command(CMD_SCHEDULE, 4'd3, 31'd20);
    send_command(CMD_SCHEDULE, 4'd5, 31'd20);
    send_command(CMD_QUERY, 4'd3, '0);
    send_command(CMD_UNSCHEDULE, 4'd9, '0);
    send_command(CMD_ADVANCE, 4'd0, 31'd5);
    send_command(CMD_SKIP, 4'd0, '0);
    send_command(CMD_ADVANCE, 4'd0, 31'h7FFF_FFFF);
    send_command(CMD_QUERY, 4'd15, '0);
    send_command(CMD_UNSCHEDULE, 4'd15, '0);
    send_command(3'd5, 4'd1, 31'd1);
    send_command(3'd7, 4'd2, '1);
    send_command(CMD_ADVANCE, 4'd0, 31'h7FFF_FFFF);
    send_command(CMD_ADVANCE, 4'd0, 31'h7FFF_FFFF);
    send_command(CMD_ADVANCE, 4'd0, 31'h7FFF_FFFF);
    send_command(CMD_ADVANCE, 4'd0, 31'h7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_all_slots_fire();
    for (int i = 15; i >= 0; i--) send_command(CMD_SCHEDULE, 4'(i), 31'(i % 3));
    send_command(CMD_SKIP, 4'd0, '0);
    send_command(CMD_SKIP, 4'd0, '0);
    send_command(CMD_ADVANCE, 4'd0, 31'd2);
  endtask

  task automatic test_backpressure();
    hold_off = 600;
    for (int i = 0; i < 16; i++) send_command(CMD_SCHEDULE, 4'(i), 31'($urandom_range(3)));
    for (int i = 0; i < 8; i++) send_command(CMD_QUERY, 4'($urandom), '0);
    send_command(CMD_ADVANCE, 4'd0, 31'd4);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [2:0] c;
    int k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        recv_idle_pct = 0;
        send_idle_pct = 0;
      end
      if (i == n / 2) begin
        recv_idle_pct = 34;
        send_idle_pct = 34;
      end
      k = $urandom_range(99);
      if (k < 35) c = CMD_SCHEDULE;
      else if (k < 55) c = CMD_ADVANCE;
      else if (k < 67) c = CMD_SKIP;
      else if (k < 77) c = CMD_UNSCHEDULE;
      else if (k < 97) c = CMD_QUERY;
      else c = 3'($urandom_range(7, 5));
      send_command(c, 4'($urandom), c == CMD_SCHEDULE || c == CMD_ADVANCE ?
                   random_delay() : 31'($urandom));
    end
  endtask

  initial begin
    sched_clock = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      sched_pending[i] = 1'b0;
      sched_due[i] = '0;
      sched_queued[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_all_slots_fire();
    test_backpressure();
    test_random(260);
    wait_drained();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
